### hdl/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and constants for the sorted-insert priority queue core.
// ----------------------------------------------------------------------------
package spq_pkg;

	localparam int DEPTH_DEF    = 8;
	localparam int KEY_BITS_DEF = 40;
	localparam int PAYLOAD_BITS = 16;
	localparam int LIMIT_BITS   = 4;

	localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = 4'd5;

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_REMOVE = 2'd1,
		OP_CLEAR  = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		STATUS_OK    = 2'd0,
		STATUS_FULL  = 2'd1,
		STATUS_EMPTY = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INS_RD,
		ST_INS_CMP,
		ST_INS_WR,
		ST_REM_RD,
		ST_REM_MOVE
	} state_t;

endpackage

### hdl/sorted_insert_priority_queue_core.sv
// ----------------------------------------------------------------------------
// sorted_insert_priority_queue_core
// Bounded priority queue kept in ascending key order in a small RAM.
// ----------------------------------------------------------------------------
// Usage:
//   Commands (op, key, payload) transfer on a clock edge with start high and
//   busy low. Every command gives exactly one result, shown for one cycle
//   with done high on status, out_key, out_payload and entry_count. The
//   receiver cannot hold results off.
//   Clear, unused op codes, a full insert and a remove on empty finish at
//   once: done rises the cycle after the transfer and busy stays low.
//   Insert walks from the tail toward the front through one key comparator,
//   moving each later-sorting entry up one place, then writes the new entry.
//   Remove reads the front and then moves each following entry down.
//   The single RAM port pair (one read, one write per cycle, read data
//   registered) sets this pace of work. done follows the last busy cycle.
//   The next command may transfer in the cycle done is high.
//   Reset clears the entry count and loads capacity_limit with 5; the RAM
//   is not cleared. cfg_wr_en writes capacity_limit; the user must do so
//   only while the core is idle, as the core itself does not enforce it.
// ----------------------------------------------------------------------------
module sorted_insert_priority_queue_core #(
	parameter int DEPTH    = spq_pkg::DEPTH_DEF,
	parameter int KEY_BITS = spq_pkg::KEY_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	output logic                                  busy,
	input  logic [1:0]                            op,
	input  logic [KEY_BITS-1:0]                   key,
	input  logic [spq_pkg::PAYLOAD_BITS-1:0]      payload,
	input  logic                                  cfg_wr_en,
	input  logic [spq_pkg::LIMIT_BITS-1:0]        cfg_wr_data,
	output logic                                  done,
	output logic [1:0]                            status,
	output logic [KEY_BITS-1:0]                   out_key,
	output logic [spq_pkg::PAYLOAD_BITS-1:0]      out_payload,
	output logic [$clog2(DEPTH+1)-1:0]            entry_count
);

	localparam int PW    = spq_pkg::PAYLOAD_BITS;
	localparam int LB    = spq_pkg::LIMIT_BITS;
	localparam int IW    = $clog2(DEPTH);
	localparam int CW    = $clog2(DEPTH + 1);
	localparam int EW    = KEY_BITS + PW;
	localparam int CMPW  = (CW > LB) ? CW : LB;

	spq_pkg::state_t  state_q, state_d;
	spq_pkg::status_t status_q;

	logic [IW-1:0]       idx_q;
	logic [KEY_BITS-1:0] key_q;
	logic [PW-1:0]       pay_q;
	logic [CW-1:0]       count_q;
	logic [LB-1:0]       limit_q;
	logic                done_q;
	logic [KEY_BITS-1:0] out_key_q;
	logic [PW-1:0]       out_pay_q;

	logic                accept;
	logic                full;
	logic [CMPW-1:0]     lim_ext, dep_ext, eff_limit;
	logic [EW-1:0]       rdata;
	logic [KEY_BITS-1:0] rd_key;
	logic [PW-1:0]       rd_pay;
	logic                key_lt, key_eq, at_front, shift_up, last_rem;
	logic                fin_ins, fin_rem;
	logic                ram_we;
	logic [IW-1:0]       ram_waddr, ram_raddr;
	logic [EW-1:0]       ram_wdata;

	assign busy   = (state_q != spq_pkg::ST_IDLE);
	assign accept = start && !busy;

	// effective limit is min(capacity_limit, DEPTH)
	assign lim_ext   = CMPW'(limit_q);
	assign dep_ext   = CMPW'(DEPTH);
	assign eff_limit = (lim_ext > dep_ext) ? dep_ext : lim_ext;
	assign full      = (CMPW'(count_q) >= eff_limit);

	assign rd_key = rdata[EW-1 -: KEY_BITS];
	assign rd_pay = rdata[PW-1:0];

	// shared comparator: move stored entry up unless it sorts before the new key;
	// an equal key at the front stays in front
	assign key_lt   = (rd_key < key_q);
	assign key_eq   = (rd_key == key_q);
	assign at_front = (idx_q == IW'(1));
	assign shift_up = !key_lt && !(key_eq && at_front);
	assign last_rem = (CW'(idx_q) == (count_q - CW'(1)));

	assign fin_ins = ((state_q == spq_pkg::ST_INS_CMP) && !shift_up) ||
	                 (state_q == spq_pkg::ST_INS_WR);
	assign fin_rem = (state_q == spq_pkg::ST_REM_MOVE) && last_rem;

	spq_ram #(
		.WIDTH (EW),
		.DEPTH (DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (rdata)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			spq_pkg::ST_IDLE: begin
				if (accept) begin
					case (op)
						spq_pkg::OP_INSERT: begin
							if (!full) begin
								state_d = (count_q == '0) ? spq_pkg::ST_INS_WR
								                          : spq_pkg::ST_INS_RD;
							end
						end
						spq_pkg::OP_REMOVE: begin
							if (count_q != '0) begin
								state_d = spq_pkg::ST_REM_RD;
							end
						end
						default: state_d = spq_pkg::ST_IDLE;
					endcase
				end
			end
			spq_pkg::ST_INS_RD:  state_d = spq_pkg::ST_INS_CMP;
			spq_pkg::ST_INS_CMP: begin
				if (shift_up) begin
					state_d = at_front ? spq_pkg::ST_INS_WR : spq_pkg::ST_INS_RD;
				end else begin
					state_d = spq_pkg::ST_IDLE;
				end
			end
			spq_pkg::ST_INS_WR:  state_d = spq_pkg::ST_IDLE;
			spq_pkg::ST_REM_RD:  state_d = spq_pkg::ST_REM_MOVE;
			spq_pkg::ST_REM_MOVE: begin
				state_d = last_rem ? spq_pkg::ST_IDLE : spq_pkg::ST_REM_RD;
			end
			default: state_d = spq_pkg::ST_IDLE;
		endcase
	end

	// RAM controls
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = idx_q;
		ram_wdata = {key_q, pay_q};
		ram_raddr = idx_q;
		unique case (state_q)
			spq_pkg::ST_IDLE: begin
				ram_we = 1'b0;
			end
			spq_pkg::ST_INS_RD: begin
				ram_raddr = idx_q - IW'(1);
			end
			spq_pkg::ST_INS_CMP: begin
				ram_we = 1'b1;
				if (shift_up) begin
					ram_wdata = rdata;
				end
			end
			spq_pkg::ST_INS_WR: begin
				ram_we = 1'b1;
			end
			spq_pkg::ST_REM_RD: begin
				ram_raddr = idx_q;
			end
			spq_pkg::ST_REM_MOVE: begin
				ram_we    = (idx_q != '0);
				ram_waddr = idx_q - IW'(1);
				ram_wdata = rdata;
			end
			default: ram_we = 1'b0;
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= spq_pkg::ST_IDLE;
			count_q  <= '0;
			limit_q  <= spq_pkg::LIMIT_RESET;
			done_q   <= 1'b0;
			status_q <= spq_pkg::STATUS_OK;
		end else begin
			state_q <= state_d;
			done_q  <= 1'b0;
			if (cfg_wr_en) begin
				limit_q <= cfg_wr_data;
			end
			if (accept) begin
				case (op)
					spq_pkg::OP_INSERT: begin
						if (full) begin
							status_q <= spq_pkg::STATUS_FULL;
							done_q   <= 1'b1;
						end
					end
					spq_pkg::OP_REMOVE: begin
						if (count_q == '0) begin
							status_q <= spq_pkg::STATUS_EMPTY;
							done_q   <= 1'b1;
						end
					end
					spq_pkg::OP_CLEAR: begin
						count_q  <= '0;
						status_q <= spq_pkg::STATUS_OK;
						done_q   <= 1'b1;
					end
					default: begin
						status_q <= spq_pkg::STATUS_OK;
						done_q   <= 1'b1;
					end
				endcase
			end
			if (fin_ins) begin
				count_q  <= count_q + CW'(1);
				status_q <= spq_pkg::STATUS_OK;
				done_q   <= 1'b1;
			end
			if (fin_rem) begin
				count_q  <= count_q - CW'(1);
				status_q <= spq_pkg::STATUS_OK;
				done_q   <= 1'b1;
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (accept) begin
			key_q     <= key;
			pay_q     <= payload;
			out_key_q <= '0;
			out_pay_q <= '0;
			if (op == spq_pkg::OP_INSERT) begin
				idx_q <= count_q[IW-1:0];
			end else begin
				idx_q <= '0;
			end
		end
		if ((state_q == spq_pkg::ST_INS_CMP) && shift_up) begin
			idx_q <= idx_q - IW'(1);
		end
		if (state_q == spq_pkg::ST_REM_MOVE) begin
			if (idx_q == '0) begin
				out_key_q <= rd_key;
				out_pay_q <= rd_pay;
			end
			idx_q <= idx_q + IW'(1);
		end
	end

	assign done        = done_q;
	assign status      = status_q;
	assign out_key     = out_key_q;
	assign out_payload = out_pay_q;
	assign entry_count = count_q;

endmodule

### hdl/spq_ram.sv
// ----------------------------------------------------------------------------
// spq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module spq_ram #(
	parameter int WIDTH = 56,
	parameter int DEPTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
